// ===== rtl/ngb_pkg.sv =====
package ngb_pkg;

   localparam logic [2:0] KIND_TOKEN  = 3'd0;
   localparam logic [2:0] KIND_MAP    = 3'd1;
   localparam logic [2:0] KIND_MULT   = 3'd2;
   localparam logic [2:0] KIND_PRIME  = 3'd3;
   localparam logic [2:0] KIND_OFFSET = 3'd4;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_VOCAB = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;
   localparam logic [1:0] ERR_LAYER = 2'd3;

   localparam logic [2:0] CSR_VOCAB_SIZE = 3'd0;
   localparam logic [2:0] CSR_COMP_SIZE  = 3'd1;
   localparam logic [2:0] CSR_PAD_ID     = 3'd2;
   localparam logic [2:0] CSR_LAYER_SEL  = 3'd3;
   localparam logic [2:0] CSR_LAYER_CNT  = 3'd4;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

endpackage

// ===== rtl/ngb_ram.sv =====
module ngb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ngb_divider.sv =====
// Restoring remainder unit: one dividend bit per cycle.
module ngb_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  ngb_pkg::div_req_type       req,
   output logic                       done,
   output logic [31:0]                remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, num_ff[63]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         num_in  = req.dividend;
         rem_in  = 32'd0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 32'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[31:0];
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/ngram_bucket_hash_top.sv =====
// Each column of a token runs the bit-serial remainder unit once; a zero
// prime skips the unit for that column.
// One item is in flight at a time; each result word leaves the output register
// when unstalled.
// Synchronous reset clears control state, configuration registers and history fill; tables hold garbage.
module ngram_bucket_hash_top #(
   parameter int WINDOW_LEN  = 3,
   parameter int NUM_HEADS   = 8,
   parameter int MAX_LAYERS  = 2,
   parameter int VOCAB_DEPTH = 131072
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [24:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic               req_seq_start,
   input  logic signed [31:0] req_token_id,
   input  logic [16:0]        req_table_index,
   input  logic [62:0]        req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_column,
   output logic [1:0]         rsp_order_index,
   output logic [3:0]         rsp_head_index,
   output logic               rsp_last,
   output logic [1:0]         rsp_error
);

   localparam int HIST  = WINDOW_LEN - 1;
   localparam int NCOLS = HIST * NUM_HEADS;
   localparam int MDEP  = MAX_LAYERS * WINDOW_LEN;
   localparam int CDEP  = MAX_LAYERS * NCOLS;
   localparam int VAW   = $clog2(VOCAB_DEPTH);
   localparam int MAW   = $clog2(MDEP);
   localparam int CAW   = $clog2(CDEP);
   localparam int IW    = $clog2(WINDOW_LEN);
   localparam int HW    = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
   localparam int FW    = $clog2(HIST + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ERR  = 4'd1;
   localparam logic [3:0] S_MAP  = 4'd2;
   localparam logic [3:0] S_MRD  = 4'd3;
   localparam logic [3:0] S_MUL  = 4'd4;
   localparam logic [3:0] S_ADD  = 4'd5;
   localparam logic [3:0] S_CRD  = 4'd6;
   localparam logic [3:0] S_CDAT = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   // configuration
   logic [17:0] vocab_ff;
   logic [24:0] comp_ff;
   logic [23:0] pad_ff;
   logic        lsel_ff;
   logic [1:0]  lcnt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vocab_ff <= 18'h20000;
         comp_ff  <= 25'h1000000;
         pad_ff   <= 24'd0;
         lsel_ff  <= 1'b0;
         lcnt_ff  <= 2'd2;
      end else if (csr_valid) begin
         case (csr_index)
            ngb_pkg::CSR_VOCAB_SIZE: vocab_ff <= csr_wdata[17:0];
            ngb_pkg::CSR_COMP_SIZE:  comp_ff  <= csr_wdata;
            ngb_pkg::CSR_PAD_ID:     pad_ff   <= csr_wdata[23:0];
            ngb_pkg::CSR_LAYER_SEL:  lsel_ff  <= csr_wdata[0];
            ngb_pkg::CSR_LAYER_CNT:  lcnt_ff  <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // control and datapath registers
   logic [3:0]   state_ff, state_in;
   logic [IW-1:0] i_ff, i_in;
   logic [HW-1:0] h_ff, h_in;
   logic [1:0]   err_ff, err_in;
   logic [FW-1:0] eff_ff, eff_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [23:0]  hist_ff [HIST];
   logic [23:0]  hist_in [HIST];
   logic [23:0]  win_ff [WINDOW_LEN];
   logic [23:0]  win_in [WINDOW_LEN];
   logic [55:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [63:0]  roll_ff, roll_in;
   logic [31:0]  prime_ff, prime_in, off_ff, off_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  col_ff, col_in;
   logic [1:0]   ord_ff, ord_in;
   logic [3:0]   head_ff, head_in;
   logic         last_ff, last_in;
   logic [1:0]   rerr_ff, rerr_in;

   // memories
   logic [23:0]  map_rdata;
   logic [63:0]  mul_rdata;
   logic [31:0]  prime_rdata, off_rdata;
   logic [MAW-1:0] mul_raddr;
   logic [CAW-1:0] col_raddr;
   logic         accept, out_free, range_bad, col_last;
   logic [63:0]  prod;
   logic [31:0]  rem_sel;
   logic         div_done;
   logic [31:0]  div_rem;
   ngb_pkg::div_req_type div_req;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign mul_raddr = MAW'(int'(lsel_ff) * WINDOW_LEN + int'(i_ff));
   assign col_raddr = CAW'(int'(lsel_ff) * NCOLS + (int'(i_ff) - 1) * NUM_HEADS + int'(h_ff));

   ngb_ram #(.WIDTH(24), .DEPTH(VOCAB_DEPTH)) u_map (
      .clock (clock),
      .we    (accept && req_kind == ngb_pkg::KIND_MAP &&
              32'(req_table_index) < 32'(VOCAB_DEPTH)),
      .waddr (VAW'(req_table_index)),
      .wdata (req_table_value[23:0]),
      .raddr (VAW'(req_token_id[30:0])),
      .rdata (map_rdata)
   );

   ngb_ram #(.WIDTH(64), .DEPTH(MDEP)) u_mult (
      .clock (clock),
      .we    (accept && req_kind == ngb_pkg::KIND_MULT &&
              32'(req_table_index) < 32'(MDEP)),
      .waddr (MAW'(req_table_index)),
      .wdata ({1'b0, req_table_value}),
      .raddr (mul_raddr),
      .rdata (mul_rdata)
   );

   ngb_ram #(.WIDTH(32), .DEPTH(CDEP)) u_prime (
      .clock (clock),
      .we    (accept && req_kind == ngb_pkg::KIND_PRIME &&
              32'(req_table_index) < 32'(CDEP)),
      .waddr (CAW'(req_table_index)),
      .wdata (req_table_value[31:0]),
      .raddr (col_raddr),
      .rdata (prime_rdata)
   );

   ngb_ram #(.WIDTH(32), .DEPTH(CDEP)) u_offset (
      .clock (clock),
      .we    (accept && req_kind == ngb_pkg::KIND_OFFSET &&
              32'(req_table_index) < 32'(CDEP)),
      .waddr (CAW'(req_table_index)),
      .wdata (req_table_value[31:0]),
      .raddr (col_raddr),
      .rdata (off_rdata)
   );

   assign div_req.start    = (state_ff == S_CDAT) && (prime_rdata != 32'd0);
   assign div_req.dividend = roll_ff[63] ? (~roll_ff + 64'd1) : roll_ff;
   assign div_req.divisor  = prime_rdata;

   ngb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      range_bad = (32'(map_rdata) >= 32'(comp_ff));
      for (int k = 1; k < WINDOW_LEN; k++) begin
         if (32'(win_ff[k]) >= 32'(comp_ff)) begin
            range_bad = 1'b1;
         end
      end
   end

   assign prod     = 64'(lo_ff) + {hi_ff[31:0], 32'd0};
   assign col_last = (int'(i_ff) == WINDOW_LEN - 1) && (int'(h_ff) == NUM_HEADS - 1);

   always_comb begin
      if (prime_ff == 32'd0) begin
         rem_sel = roll_ff[31:0];
      end else if (roll_ff[63]) begin
         rem_sel = 32'd0 - div_rem;
      end else begin
         rem_sel = div_rem;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      h_in     = h_ff;
      err_in   = err_ff;
      eff_in   = eff_ff;
      fill_in  = fill_ff;
      hist_in  = hist_ff;
      win_in   = win_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      roll_in  = roll_ff;
      prime_in = prime_ff;
      off_in   = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      col_in   = col_ff;
      ord_in   = ord_ff;
      head_in  = head_ff;
      last_in  = last_ff;
      rerr_in  = rerr_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_kind == ngb_pkg::KIND_TOKEN) begin
               eff_in = req_seq_start ? FW'(0) : fill_ff;
               for (int k = 1; k < WINDOW_LEN; k++) begin
                  win_in[k] = (k <= int'(eff_in)) ? hist_ff[k-1] : pad_ff;
               end
               if (2'(lsel_ff) >= lcnt_ff || int'(lsel_ff) >= MAX_LAYERS) begin
                  err_in   = ngb_pkg::ERR_LAYER;
                  state_in = S_ERR;
               end else if (req_token_id[31] ||
                            req_token_id[30:0] >= 31'(vocab_ff) ||
                            {1'b0, req_token_id[30:0]} >= 32'(VOCAB_DEPTH)) begin
                  err_in   = ngb_pkg::ERR_VOCAB;
                  state_in = S_ERR;
               end else begin
                  state_in = S_MAP;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               col_in   = 32'd0;
               ord_in   = 2'd0;
               head_in  = 4'd0;
               last_in  = 1'b1;
               rerr_in  = err_ff;
               state_in = S_IDLE;
            end
         end
         S_MAP: begin
            win_in[0] = map_rdata;
            if (range_bad) begin
               err_in   = ngb_pkg::ERR_RANGE;
               state_in = S_ERR;
            end else begin
               i_in     = IW'(0);
               state_in = S_MRD;
            end
         end
         S_MRD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            lo_in    = 56'(win_ff[i_ff] * mul_rdata[31:0]);
            hi_in    = 56'(win_ff[i_ff] * mul_rdata[63:32]);
            state_in = S_ADD;
         end
         S_ADD: begin
            if (i_ff == IW'(0)) begin
               roll_in  = prod;
               i_in     = IW'(1);
               state_in = S_MRD;
            end else begin
               roll_in  = roll_ff ^ prod;
               h_in     = HW'(0);
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            state_in = S_CDAT;
         end
         S_CDAT: begin
            prime_in = prime_rdata;
            off_in   = off_rdata;
            state_in = (prime_rdata == 32'd0) ? S_OUT : S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               col_in   = rem_sel + off_ff;
               ord_in   = 2'(i_ff - IW'(1));
               head_in  = 4'(h_ff);
               last_in  = col_last;
               rerr_in  = ngb_pkg::ERR_NONE;
               if (int'(h_ff) < NUM_HEADS - 1) begin
                  h_in     = h_ff + HW'(1);
                  state_in = S_CRD;
               end else if (int'(i_ff) < WINDOW_LEN - 1) begin
                  i_in     = i_ff + IW'(1);
                  state_in = S_MRD;
               end else begin
                  // shift the new id into history
                  for (int k = HIST - 1; k > 0; k--) begin
                     hist_in[k] = hist_ff[k-1];
                  end
                  hist_in[0] = win_ff[0];
                  fill_in = (int'(eff_ff) + 1 < HIST) ? eff_ff + FW'(1) : FW'(HIST);
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= FW'(0);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff     <= i_in;
      h_ff     <= h_in;
      err_ff   <= err_in;
      eff_ff   <= eff_in;
      hist_ff  <= hist_in;
      win_ff   <= win_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      roll_ff  <= roll_in;
      prime_ff <= prime_in;
      off_ff   <= off_in;
      col_ff   <= col_in;
      ord_ff   <= ord_in;
      head_ff  <= head_in;
      last_ff  <= last_in;
      rerr_ff  <= rerr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = col_ff;
   assign rsp_order_index = ord_ff;
   assign rsp_head_index  = head_ff;
   assign rsp_last        = last_ff;
   assign rsp_error       = rerr_ff;

endmodule

// ===== tb/ngram_bucket_hash_checker.sv =====
`timescale 1ns / 100ps

module ngram_bucket_hash_checker #(
   parameter int WINDOW_LEN  = 3,
   parameter int NUM_HEADS   = 8,
   parameter int MAX_LAYERS  = 2,
   parameter int VOCAB_DEPTH = 131072
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [24:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic               req_seq_start,
   input  logic signed [31:0] req_token_id,
   input  logic [16:0]        req_table_index,
   input  logic [62:0]        req_table_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [31:0]        rsp_column,
   input  logic [1:0]         rsp_order_index,
   input  logic [3:0]         rsp_head_index,
   input  logic               rsp_last,
   input  logic [1:0]         rsp_error,
   output int                 fail_count,
   output int                 pending
);

   localparam int NCOLS      = (WINDOW_LEN - 1) * NUM_HEADS;
   localparam int MULT_DEPTH = MAX_LAYERS * WINDOW_LEN;
   localparam int COL_DEPTH  = MAX_LAYERS * NCOLS;

   typedef struct {
      logic [31:0] column;
      logic [1:0]  order;
      logic [3:0]  head;
      logic        last;
      logic [1:0]  err;
   } bucket_type;

   bucket_type bucket_q[$];

   logic [17:0] vocab_size;
   logic [24:0] comp_size;
   logic [23:0] pad_id;
   logic        layer_sel;
   logic [1:0]  layer_cnt;

   logic [23:0] history [WINDOW_LEN-1];
   int          fill;
   logic [23:0] map_mem [int];
   logic [63:0] mult_mem [MULT_DEPTH];
   logic [31:0] prime_mem [COL_DEPTH];
   logic [31:0] offset_mem [COL_DEPTH];

   function automatic logic [31:0] bucket_of(logic [63:0] roll, logic [31:0] p,
                                             logic [31:0] off);
      logic [63:0] mag;
      logic [31:0] r;
      if (p == 0) begin
         r = roll[31:0];
      end else if (roll[63]) begin
         // remainder keeps the sign of the dividend
         mag = -roll;
         r = 32'd0 - 32'(mag % 64'(p));
      end else begin
         r = 32'(roll % 64'(p));
      end
      return r + off;
   endfunction

   task automatic push_error(logic [1:0] code);
      bucket_type b;
      b = '{32'd0, 2'd0, 4'd0, 1'b1, code};
      bucket_q.push_back(b);
   endtask

   task automatic hash_token(logic start, logic signed [31:0] tid);
      logic [23:0] win [WINDOW_LEN];
      logic [63:0] roll;
      logic [63:0] prod;
      int          eff;
      int          c;
      int          sel;
      bucket_type  b;
      sel = int'(layer_sel);
      if (sel >= int'(layer_cnt) || sel >= MAX_LAYERS) begin
         push_error(ngb_pkg::ERR_LAYER);
         return;
      end
      if (tid < 0 || int'(tid) >= int'(vocab_size) || int'(tid) >= VOCAB_DEPTH) begin
         push_error(ngb_pkg::ERR_VOCAB);
         return;
      end
      eff = start ? 0 : fill;
      win[0] = map_mem.exists(int'(tid)) ? map_mem[int'(tid)] : 24'd0;
      for (int i = 1; i < WINDOW_LEN; i++)
         win[i] = (i <= eff) ? history[i-1] : pad_id;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (25'(win[i]) >= comp_size) begin
            push_error(ngb_pkg::ERR_RANGE);
            return;
         end
      end
      roll = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         prod = 64'(win[i]) * mult_mem[sel * WINDOW_LEN + i];
         if (i == 0) begin
            roll = prod;
         end else begin
            roll ^= prod;
            for (int h = 0; h < NUM_HEADS; h++) begin
               c = sel * NCOLS + (i - 1) * NUM_HEADS + h;
               b.column = bucket_of(roll, prime_mem[c], offset_mem[c]);
               b.order  = 2'(i - 1);
               b.head   = 4'(h);
               b.last   = (i == WINDOW_LEN - 1) && (h == NUM_HEADS - 1);
               b.err    = ngb_pkg::ERR_NONE;
               bucket_q.push_back(b);
            end
         end
      end
      for (int i = WINDOW_LEN - 2; i > 0; i--)
         history[i] = history[i-1];
      history[0] = win[0];
      fill = (eff + 1 < WINDOW_LEN - 1) ? eff + 1 : WINDOW_LEN - 1;
   endtask

   always @(posedge clock) begin : watch
      bucket_type want;
      if (reset) begin
         vocab_size = 18'd131072;
         comp_size  = 25'd16777216;
         pad_id     = '0;
         layer_sel  = 1'b0;
         layer_cnt  = 2'd2;
         fill       = 0;
         for (int i = 0; i < WINDOW_LEN - 1; i++)
            history[i] = '0;
         bucket_q.delete();
      end else begin
         // retire the result word before predicting a new item on the same edge
         if (rsp_valid && !rsp_stall) begin
            if (bucket_q.size() == 0) begin
               $error("unexpected result word: column %h", rsp_column);
               fail_count++;
            end else begin
               want = bucket_q.pop_front();
               if (rsp_column !== want.column) begin
                  $error("column: expected %h, actual %h", want.column, rsp_column);
                  fail_count++;
               end
               if (rsp_order_index !== want.order) begin
                  $error("order_index: expected %0d, actual %0d", want.order,
                         rsp_order_index);
                  fail_count++;
               end
               if (rsp_head_index !== want.head) begin
                  $error("head_index: expected %0d, actual %0d", want.head,
                         rsp_head_index);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  fail_count++;
               end
               if (rsp_error !== want.err) begin
                  $error("error: expected %0d, actual %0d", want.err, rsp_error);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ngb_pkg::CSR_VOCAB_SIZE: vocab_size = csr_wdata[17:0];
               ngb_pkg::CSR_COMP_SIZE:  comp_size  = csr_wdata;
               ngb_pkg::CSR_PAD_ID:     pad_id     = csr_wdata[23:0];
               ngb_pkg::CSR_LAYER_SEL:  layer_sel  = csr_wdata[0];
               ngb_pkg::CSR_LAYER_CNT:  layer_cnt  = csr_wdata[1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_kind)
               ngb_pkg::KIND_TOKEN:  hash_token(req_seq_start, req_token_id);
               ngb_pkg::KIND_MAP:    if (int'(req_table_index) < VOCAB_DEPTH)
                                        map_mem[int'(req_table_index)] =
                                           req_table_value[23:0];
               ngb_pkg::KIND_MULT:   if (int'(req_table_index) < MULT_DEPTH)
                                        mult_mem[int'(req_table_index)] =
                                           {1'b0, req_table_value};
               ngb_pkg::KIND_PRIME:  if (int'(req_table_index) < COL_DEPTH)
                                        prime_mem[int'(req_table_index)] =
                                           req_table_value[31:0];
               ngb_pkg::KIND_OFFSET: if (int'(req_table_index) < COL_DEPTH)
                                        offset_mem[int'(req_table_index)] =
                                           req_table_value[31:0];
               default: ;
            endcase
         end
      end
      pending = bucket_q.size();
   end

endmodule

// ===== tb/ngram_bucket_hash_top_tb.sv =====
`timescale 1ns / 100ps

module ngram_bucket_hash_top_tb;

   localparam int MULT_DEPTH = 6;
   localparam int COL_DEPTH  = 32;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [24:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_kind = '0;
   logic               req_seq_start = 1'b0;
   logic signed [31:0] req_token_id = '0;
   logic [16:0]        req_table_index = '0;
   logic [62:0]        req_table_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_column;
   logic [1:0]         rsp_order_index;
   logic [3:0]         rsp_head_index;
   logic               rsp_last;
   logic [1:0]         rsp_error;

   int  fail_count;
   int  pending;
   bit  hold_rsp = 1'b0;
   bit  sender_quiet = 1'b0;
   int  mapped_ids[$];
   int  vocab_now = 131072;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ngram_bucket_hash_top u_top (.*);

   ngram_bucket_hash_checker u_checker (.*);

   initial begin
      #20ms;
      $display("ngram_bucket_hash_top verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [62:0] rand_value();
      return 63'({$urandom, $urandom});
   endfunction

   // result side: short random stalls, quiet stretches, and one long hold
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b0;
            repeat (200) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [2:0] kind, logic start, logic signed [31:0] tid,
                            logic [16:0] idx, logic [62:0] val);
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_seq_start   <= start;
      req_token_id    <= tid;
      req_table_index <= idx;
      req_table_value <= val;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      if (kind == ngb_pkg::KIND_MAP) mapped_ids.push_back(int'(idx));
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic [2:0] index, logic [24:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      if (index == ngb_pkg::CSR_VOCAB_SIZE) vocab_now = int'(data[17:0]);
   endtask

   // drain every expected word, then let trailing table writes settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_regs(int vocab, int comp, int pad, int sel, int cnt);
      write_csr(ngb_pkg::CSR_VOCAB_SIZE, 25'(vocab));
      write_csr(ngb_pkg::CSR_COMP_SIZE, 25'(comp));
      write_csr(ngb_pkg::CSR_PAD_ID, 25'(pad));
      write_csr(ngb_pkg::CSR_LAYER_SEL, 25'(sel));
      write_csr(ngb_pkg::CSR_LAYER_CNT, 25'(cnt));
      csr_valid <= 1'b0;
   endtask

   // returns 1 for token and table words, 0 for unused kinds
   task automatic random_word(output bit counted);
      int          r;
      logic [31:0] tid;
      logic [2:0]  k;
      r = $urandom_range(0, 99);
      counted = 1'b1;
      if (r < 70) begin
         tid = mapped_ids[$urandom_range(0, mapped_ids.size() - 1)];
         send_word(ngb_pkg::KIND_TOKEN, $urandom_range(0, 4) == 0, tid, 17'($urandom),
                   rand_value());
      end else if (r < 78) begin
         // outside the vocabulary: never touches an unwritten map entry
         tid = $urandom;
         if (!tid[31] && int'(tid) < vocab_now) tid[31] = 1'b1;
         send_word(ngb_pkg::KIND_TOKEN, 1'($urandom), tid, 17'($urandom), rand_value());
      end else if (r < 90) begin
         k = 3'($urandom_range(1, 4));
         if (k == ngb_pkg::KIND_MAP)
            send_word(k, 1'($urandom), $urandom, 17'($urandom),
                      $urandom_range(0, 1) ? rand_value() : 63'($urandom_range(0, 15)));
         else
            send_word(k, 1'($urandom), $urandom,
                      17'($urandom_range(0, k == ngb_pkg::KIND_MULT ? 7 : 35)),
                      rand_value());
      end else begin
         counted = 1'b0;
         send_word(3'($urandom_range(5, 7)), 1'($urandom), $urandom, 17'($urandom),
                   rand_value());
      end
   endtask

   initial begin
      int  sent;
      bit  counted;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // load every table entry a token can read
      for (int i = 0; i < MULT_DEPTH; i++)
         send_word(ngb_pkg::KIND_MULT, 1'b0, 0, 17'(i),
                   i == 0 ? 63'h7FFF_FFFF_FFFF_FFFF : rand_value());
      for (int i = 0; i < COL_DEPTH; i++) begin
         send_word(ngb_pkg::KIND_PRIME, 1'b0, 0, 17'(i),
                   i == 0 ? 63'd0 : i == 1 ? 63'hFFFF_FFFF : i == 2 ? 63'd1 :
                   i < 10 ? 63'($urandom_range(2, 1000)) : rand_value());
         send_word(ngb_pkg::KIND_OFFSET, 1'b0, 0, 17'(i),
                   i == 1 ? 63'hFFFF_FFFF : rand_value());
      end
      send_word(ngb_pkg::KIND_MAP, 1'b0, 0, 17'd0, 63'd0);
      send_word(ngb_pkg::KIND_MAP, 1'b0, 0, 17'd1, 63'hFF_FFFF);
      send_word(ngb_pkg::KIND_MAP, 1'b0, 0, 17'd131071, rand_value());
      for (int i = 0; i < 8; i++)
         send_word(ngb_pkg::KIND_MAP, 1'b0, 0, 17'($urandom),
                   i < 4 ? 63'($urandom_range(0, 15)) : rand_value());

      // directed: extremes, sequence starts, ignored writes and unused kinds
      send_word(ngb_pkg::KIND_MULT, 1'b0, 0, 17'd6, rand_value());
      send_word(ngb_pkg::KIND_PRIME, 1'b0, 0, 17'd32, rand_value());
      send_word(ngb_pkg::KIND_OFFSET, 1'b0, 0, 17'h1FFFF, rand_value());
      send_word(ngb_pkg::KIND_TOKEN, 1'b1, 0, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b0, 131071, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b0, 1, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b0, 131071, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b1, 1, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b0, -1, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b0, 32'sh8000_0000, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b0, 32'sh7FFF_FFFF, '0, '0);
      send_word(ngb_pkg::KIND_TOKEN, 1'b0, 131072, '0, '0);
      send_word(3'd5, 1'b1, -1, 17'h1FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      send_word(3'd6, 1'b0, 0, '0, '0);
      send_word(3'd7, 1'b0, 0, '0, '0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_regs(131072, 16777216, 0, 1, 2);
            1: set_regs(1, 1, 16777215, 0, 1);
            2: set_regs(131072, 16777216, 16777215, 1, 1);
            default: set_regs($urandom_range(200, 131072), $urandom_range(16, 1 << 16),
                              $urandom_range(0, 15), 1, 3);
         endcase
         sender_quiet = (ph == 2);
         sent = 0;
         while (sent < 8) begin
            if (ph == 0 && sent == 3) hold_rsp = 1'b1;
            // pause until every result is back, midway through the last phase
            if (ph == 3 && sent == 4) drain();
            random_word(counted);
            if (counted) sent++;
         end
         drain();
      end

      set_regs(131072, 16777216, 0, 0, 2);
      sent = 0;
      while (sent < 6) begin
         random_word(counted);
         if (counted) sent++;
      end
      drain();

      if (fail_count == 0)
         $display("ngram_bucket_hash_top verification clean");
      else
         $display("ngram_bucket_hash_top verification failed");
      $finish;
   end

endmodule
